[rtl/core/b85_pkg.sv]
// Package for the base85 text decoder: character codes, pass-through types
// and the power-of-85 constant table. Used by every module of the block but the checker.
`default_nettype none

package b85_pkg;

    localparam logic [7:0] BLANK_MAX  = 8'h20;
    localparam logic [7:0] DIGIT_LOW  = 8'h21;
    localparam logic [7:0] DIGIT_HIGH = 8'h75;
    localparam logic [7:0] ZERO_GROUP = 8'h7A;

    localparam int WORD_W  = 32;
    localparam int DIGIT_W = 7;
    localparam int COUNT_W = 3;
    localparam int BYTE_W  = 8;

    localparam logic [COUNT_W-1:0] LAST_DIGIT = 3'd4;
    localparam logic [COUNT_W-1:0] MIN_FLUSH  = 3'd2;
    localparam logic [COUNT_W-1:0] GROUP_LEN  = 3'd5;

    // One character item held in the input register.
    typedef struct packed {
        logic              eot;
        logic [BYTE_W-1:0] ch;
    } b85_item_t;

    // A decoded four-byte group handed to the output serializer.
    typedef struct packed {
        logic              load;
        logic [WORD_W-1:0] word;
    } b85_grp_t;

    // 85 to the power n, modulo 2^32.
    function automatic logic [WORD_W-1:0] pow85(input logic [COUNT_W-1:0] n);
        logic [WORD_W-1:0] r;
        unique case (n)
            3'd0:    r = 32'd1;
            3'd1:    r = 32'd85;
            3'd2:    r = 32'd7225;
            3'd3:    r = 32'd614125;
            3'd4:    r = 32'd52200625;
            3'd5:    r = 32'd142085829;
            default: r = 32'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/b85_in_reg.sv]
// Input register of the base85 decoder: holds one accepted character item.
// Depends on b85_pkg for the item type.
`default_nettype none

module b85_in_reg
    import b85_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic      s_tlast,
    input  wire logic      take,
    output logic           item_valid,
    output b85_item_t      item
);

    logic      valid_reg;
    logic      valid_next;
    b85_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ch  <= s_tdata;
            item_reg.eot <= s_tlast;
        end
    end

endmodule

`default_nettype wire

[rtl/core/b85_decode.sv]
// Group decoder: accumulator, digit count and halt flag, and the single
// multiply-add that forms each group word but the all-zero one. Depends on b85_pkg.
`default_nettype none

module b85_decode
    import b85_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      item_valid,
    input  wire b85_item_t item,
    input  wire logic      res_free,
    output logic           take,
    output b85_grp_t       grp
);

    logic [WORD_W-1:0]  acc_reg;
    logic [WORD_W-1:0]  acc_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               halted_reg;
    logic               halted_next;

    logic               is_blank;
    logic               is_digit;
    logic               is_zero_grp;
    logic [DIGIT_W-1:0] digit;
    logic               emit;
    logic               zero_word;
    logic [COUNT_W-1:0] m_exp;
    logic [COUNT_W-1:0] p_exp;
    logic [DIGIT_W-1:0] e_val;
    logic [WORD_W-1:0]  prod_acc;
    logic [WORD_W-1:0]  prod_e;
    logic [WORD_W-1:0]  word;

    assign is_blank    = item.ch <= BLANK_MAX;
    assign is_digit    = (item.ch >= DIGIT_LOW) && (item.ch <= DIGIT_HIGH);
    assign is_zero_grp = (item.ch == ZERO_GROUP) && (cnt_reg == '0);
    assign digit       = DIGIT_W'(item.ch - DIGIT_LOW);

    // The group word is acc * 85^m + e * 85^p - 1; padding with digit 84
    // reduces to this form for every flush case.
    assign prod_acc = acc_reg * pow85(m_exp);
    assign prod_e   = WORD_W'(e_val) * pow85(p_exp);
    assign word     = prod_acc + prod_e - WORD_W'(1);

    always_comb begin
        emit        = 1'b0;
        zero_word   = 1'b0;
        m_exp       = 3'd1;
        p_exp       = 3'd0;
        e_val       = DIGIT_W'(1);
        acc_next    = acc_reg;
        cnt_next    = cnt_reg;
        halted_next = halted_reg;
        if (!halted_reg) begin
            priority if (is_blank) begin
                m_exp = GROUP_LEN - cnt_reg;
                p_exp = GROUP_LEN - cnt_reg;
                emit  = item.eot && (cnt_reg >= MIN_FLUSH);
            end else if (is_zero_grp) begin
                emit      = 1'b1;
                zero_word = 1'b1;
            end else if (is_digit) begin
                e_val = digit + DIGIT_W'(1);
                if (item.eot) begin
                    m_exp = GROUP_LEN - cnt_reg;
                    p_exp = LAST_DIGIT - cnt_reg;
                    emit  = cnt_reg != '0;
                end else begin
                    emit = cnt_reg == LAST_DIGIT;
                    if (cnt_reg == LAST_DIGIT) begin
                        acc_next = '0;
                        cnt_next = '0;
                    end else begin
                        acc_next = word;
                        cnt_next = cnt_reg + COUNT_W'(1);
                    end
                end
            end else begin
                m_exp       = GROUP_LEN - cnt_reg;
                p_exp       = GROUP_LEN - cnt_reg;
                emit        = cnt_reg >= MIN_FLUSH;
                acc_next    = '0;
                cnt_next    = '0;
                halted_next = 1'b1;
            end
        end
        if (item.eot) begin
            acc_next    = '0;
            cnt_next    = '0;
            halted_next = 1'b0;
        end
    end

    assign take     = item_valid && (!emit || res_free);
    assign grp.load = take && emit;
    assign grp.word = zero_word ? '0 : word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
        end else if (take) begin
            acc_reg    <= acc_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/b85_out_ser.sv]
// Output serializer: holds one group word and sends it as four bytes,
// most significant first. Depends on b85_pkg for the group type.
`default_nettype none

module b85_out_ser
    import b85_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire b85_grp_t   grp,
    output logic            res_free,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    logic [WORD_W-1:0] word_reg;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;
    logic              valid_reg;
    logic              valid_next;
    logic              last_byte;

    assign last_byte = idx_reg == 2'd3;
    assign res_free  = !valid_reg || (m_tready && last_byte);
    assign m_tvalid  = valid_reg;
    assign m_tlast   = last_byte;

    always_comb begin
        unique case (idx_reg)
            2'd0:    m_tdata = word_reg[31:24];
            2'd1:    m_tdata = word_reg[23:16];
            2'd2:    m_tdata = word_reg[15:8];
            default: m_tdata = word_reg[7:0];
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (grp.load) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (valid_reg && m_tready) begin
            idx_next = idx_reg + 2'd1;
            if (last_byte) begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (grp.load) begin
            word_reg <= grp.word;
        end
    end

endmodule

`default_nettype wire

[rtl/core/base85_text_decoder.sv]
// Base85 text decoder top level: input register, group decoder, serializer.
// The first byte of a group is valid on the output once the item that completes
// the group has passed the input register and the serializer's word register.
// Throughput: one character per cycle while no group is waiting; each
// decoded group occupies the output port for four byte items, which is the
// limit set by the output serializer.
// Reset: synchronous, active low; clears the control state and drops both valids; data registers are not reset.
`default_nettype none

module base85_text_decoder
    import b85_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // text_char
    input  wire logic       s_tlast,   // end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast    // group_done
);

    logic      take;
    logic      item_valid;
    b85_item_t item;
    logic      res_free;
    b85_grp_t  grp;

    b85_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    b85_decode u_decode (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .res_free   (res_free),
        .take       (take),
        .grp        (grp)
    );

    b85_out_ser u_out_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .grp      (grp),
        .res_free (res_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

[rtl/core/b85_checker.sv]
// Port-level checker for the base85 text decoder, bound to the top level.
// Depends only on the top-level ports.
`default_nettype none

module b85_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    logic [1:0] pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            pos_reg <= pos_reg + 2'd1;
        end
    end

    // Every fourth output item, and only that one, closes a group.
    a_group_done_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (pos_reg == 2'd3)))
        else $error("group_done out of step with byte position");

    // A stalled output item holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output item changed");

    // With nothing pending on the output the input side never stalls.
    a_in_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with idle output");

endmodule

bind base85_text_decoder b85_checker u_b85_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
